[rtl/handheld_console_divider_timer_unit_defines.svh]
// Assertion macros for the handheld console divider timer unit.
`ifndef HANDHELD_CONSOLE_DIVIDER_TIMER_UNIT_DEFINES_SVH
`define HANDHELD_CONSOLE_DIVIDER_TIMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside of reset.
`define HCDT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcdt assertion failed");
// Next-cycle implication, checked outside of reset.
`define HCDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcdt assertion failed");
`else
`define HCDT_ASSERT_NOW(label, clk, rst, ante, cons)
`define HCDT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/hcdt_pkg.sv]
// Types and constants shared by the divider timer unit modules.
package hcdt_pkg;

   // Operation codes of an input item.
   localparam logic [3:0] OP_TICK      = 4'd0;
   localparam logic [3:0] OP_WRITE_DIV = 4'd1;
   localparam logic [3:0] OP_WRITE_TIMA = 4'd2;
   localparam logic [3:0] OP_WRITE_TMA = 4'd3;
   localparam logic [3:0] OP_WRITE_TAC = 4'd4;
   localparam logic [3:0] OP_READ_DIV  = 4'd5;
   localparam logic [3:0] OP_READ_TIMA = 4'd6;
   localparam logic [3:0] OP_READ_TMA  = 4'd7;
   localparam logic [3:0] OP_READ_TAC  = 4'd8;

   // Control register enable bit, reload delay length and counter maximum.
   localparam int unsigned TAC_ENABLE_BIT = 2;
   localparam logic [2:0] RELOAD_TICKS = 3'd4;
   localparam logic [7:0] COUNTER_MAX = 8'hff;

   // Divider bit watched for each speed setting.
   localparam logic [15:0] TAP_MASK [4] = '{16'h0200, 16'h0008, 16'h0020, 16'h0080};

   typedef struct packed {
      logic [3:0] operation;
      logic [7:0] write_data;
   } hcdt_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_interrupt;
   } hcdt_result_type;

   // True when the divider bit selected by the control value is set.
   function automatic logic tap_set(input logic [15:0] div, input logic [7:0] ctl);
      tap_set = (div & TAP_MASK[ctl[1:0]]) != 16'd0;
   endfunction

endpackage

[rtl/handheld_console_divider_timer_unit.sv]
// Top level of the divider timer unit: input register, core and result register.
// Usage: each item on the req_ channel is a tick or a DIV/TIMA/TMA/TAC access,
// given by req_operation and req_write_data. Every item yields exactly one
// item on the rsp_ channel: rsp_read_data for reads, rsp_timer_interrupt
// when the item overflowed the counter.
// An accepted item is loaded into the input register; when it moves on, the core
// runs the timer update and the result register is loaded with its result.
// Throughput is one item per cycle while rsp_stall is low, set by the
// single-pass state update in the core.
// When rsp_stall is high with a result waiting, the input register still
// holds one more item, after which req_stall rises until the result is taken.
// Synchronous reset clears the divider, TIMA, TMA, TAC, the reload delay
// and window, and empties both registers.
`include "handheld_console_divider_timer_unit_defines.svh"

module handheld_console_divider_timer_unit
   import hcdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_operation,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_timer_interrupt
);

   logic            in_valid_ff, in_valid_in;
   hcdt_item_type   in_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   hcdt_result_type rsp_result_ff;
   hcdt_result_type core_result;
   logic            advance;
   logic            accept;

   // The held item moves on when the result register is free or being taken.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   hcdt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (core_result)
   );

   // Valid flags of the two registers.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.operation  <= req_operation;
         in_item_ff.write_data <= req_write_data;
      end
      if (advance) begin
         rsp_result_ff <= core_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_result_ff.read_data;
   assign rsp_timer_interrupt = rsp_result_ff.timer_interrupt;

   // An interrupt only comes from ticks and writes, which read back zero.
   `HCDT_ASSERT_NOW(a_irq_no_data, clock, reset, rsp_valid_ff && rsp_timer_interrupt, rsp_read_data == 8'd0)
   // The input side is only held back by an item that cannot move on.
   `HCDT_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && rsp_valid_ff && rsp_stall)
   // An accepted item is held in the input register on the next cycle.
   `HCDT_ASSERT_NEXT(a_accept_holds, clock, reset, accept, in_valid_ff)
   // A moved item always produces a waiting result.
   `HCDT_ASSERT_NEXT(a_advance_result, clock, reset, advance, rsp_valid_ff)

endmodule

[rtl/hcdt_core.sv]
// Timer state registers and the single-pass update logic for one item.
module hcdt_core
   import hcdt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  hcdt_item_type   item,
   output hcdt_result_type result
);

   logic [15:0] divider_ff, divider_in;
   logic [7:0]  counter_ff, counter_in;
   logic [7:0]  modulo_ff, modulo_in;
   logic [7:0]  control_ff, control_in;
   logic [2:0]  delay_ff, delay_in;
   logic        window_ff, window_in;

   // Next state and result for the item held in the input register.
   always_comb begin
      logic       bump;
      logic [2:0] delay_dec;
      divider_in = divider_ff;
      counter_in = counter_ff;
      modulo_in  = modulo_ff;
      control_in = control_ff;
      delay_in   = delay_ff;
      window_in  = window_ff;
      bump       = 1'b0;
      delay_dec  = delay_ff - 3'd1;
      result     = '0;
      unique case (item.operation)
         OP_TICK: begin
            divider_in = divider_ff + 16'd1;
            window_in  = 1'b0;
            if (delay_ff != 3'd0) begin
               delay_in = delay_dec;
               if (delay_dec == 3'd0) begin
                  counter_in = modulo_ff;
                  window_in  = 1'b1;
               end
            end
            bump = control_ff[TAC_ENABLE_BIT] && tap_set(divider_ff, control_ff) &&
                   !tap_set(divider_in, control_ff);
         end
         OP_WRITE_DIV: begin
            bump       = control_ff[TAC_ENABLE_BIT] && tap_set(divider_ff, control_ff);
            divider_in = 16'd0;
         end
         OP_WRITE_TIMA: begin
            if (!window_ff) begin
               counter_in = item.write_data;
               delay_in   = 3'd0;
            end
         end
         OP_WRITE_TMA: begin
            modulo_in = item.write_data;
            if (window_ff) begin
               counter_in = item.write_data;
            end
         end
         OP_WRITE_TAC: begin
            bump = control_ff[TAC_ENABLE_BIT] && !item.write_data[TAC_ENABLE_BIT] &&
                   tap_set(divider_ff, control_ff);
            control_in = item.write_data;
         end
         OP_READ_DIV:  result.read_data = divider_ff[15:8];
         OP_READ_TIMA: result.read_data = counter_ff;
         OP_READ_TMA:  result.read_data = modulo_ff;
         OP_READ_TAC:  result.read_data = control_ff;
         default: ;
      endcase
      // Counter increment; an overflow starts the reload delay.
      if (bump) begin
         if (counter_in == COUNTER_MAX) begin
            counter_in             = 8'd0;
            delay_in               = RELOAD_TICKS;
            result.timer_interrupt = 1'b1;
         end else begin
            counter_in = counter_in + 8'd1;
         end
      end
   end

   // State is committed when the item moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= '0;
         counter_ff <= '0;
         modulo_ff  <= '0;
         control_ff <= '0;
         delay_ff   <= '0;
         window_ff  <= 1'b0;
      end else if (advance) begin
         divider_ff <= divider_in;
         counter_ff <= counter_in;
         modulo_ff  <= modulo_in;
         control_ff <= control_in;
         delay_ff   <= delay_in;
         window_ff  <= window_in;
      end
   end

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the divider timer unit with a built-in timer predictor.
module tb_top
   import hcdt_pkg::*;
;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SEGMENTS = 38;
   localparam int unsigned SEGMENT_ITEMS = 37;
   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned TAIL_CYCLES = 8;

   // Predicts the timer registers and keeps the results still to come, oldest first.
   class timer_scoreboard;
      logic [15:0] divider;
      logic [7:0] tima;
      logic [7:0] tma;
      logic [7:0] tac;
      logic [2:0] reload_count;
      logic reload_window;
      hcdt_result_type awaited_rsp[$];
      int unsigned mismatches;

      function new();
         divider = '0;
         tima = '0;
         tma = '0;
         tac = '0;
         reload_count = '0;
         reload_window = 1'b0;
         mismatches = 0;
      endfunction

      // The divider bit that the speed field of a control value watches.
      function logic watched_bit(input logic [15:0] div, input logic [7:0] ctl);
         case (ctl[1:0])
            2'd0: watched_bit = div[9];
            2'd1: watched_bit = div[3];
            2'd2: watched_bit = div[5];
            default: watched_bit = div[7];
         endcase
      endfunction

      // One increment of TIMA; an overflow starts the reload delay.
      function logic count_up();
         if (tima == COUNTER_MAX) begin
            tima = '0;
            reload_count = RELOAD_TICKS;
            return 1'b1;
         end
         tima = tima + 8'd1;
         return 1'b0;
      endfunction

      // Applies one accepted item to the predicted state and queues its result.
      function void note_item(input logic [3:0] op, input logic [7:0] data);
         hcdt_result_type res;
         logic [15:0] prev_div;
         res = '0;
         prev_div = divider;
         case (op)
            OP_TICK: begin
               divider = divider + 16'd1;
               reload_window = 1'b0;
               if (reload_count != 3'd0) begin
                  reload_count = reload_count - 3'd1;
                  if (reload_count == 3'd0) begin
                     tima = tma;
                     reload_window = 1'b1;
                  end
               end
               if (tac[TAC_ENABLE_BIT] && watched_bit(prev_div, tac) &&
                   !watched_bit(divider, tac))
                  res.timer_interrupt = count_up();
            end
            OP_WRITE_DIV: begin
               if (tac[TAC_ENABLE_BIT] && watched_bit(divider, tac))
                  res.timer_interrupt = count_up();
               divider = '0;
            end
            OP_WRITE_TIMA: begin
               if (!reload_window) begin
                  tima = data;
                  reload_count = '0;
               end
            end
            OP_WRITE_TMA: begin
               tma = data;
               if (reload_window)
                  tima = tma;
            end
            OP_WRITE_TAC: begin
               if (tac[TAC_ENABLE_BIT] && !data[TAC_ENABLE_BIT] && watched_bit(divider, tac))
                  res.timer_interrupt = count_up();
               tac = data;
            end
            OP_READ_DIV: res.read_data = divider[15:8];
            OP_READ_TIMA: res.read_data = tima;
            OP_READ_TMA: res.read_data = tma;
            OP_READ_TAC: res.read_data = tac;
            default: ;
         endcase
         awaited_rsp.push_back(res);
      endfunction

      // Compares one accepted result with the oldest prediction.
      function void check_result(input logic [7:0] read_data, input logic interrupt);
         hcdt_result_type want;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected result: read_data expected none actual %02h, %s %0b",
                     $time, read_data, "interrupt expected none actual", interrupt);
            mismatches++;
            return;
         end
         want = awaited_rsp.pop_front();
         if (read_data !== want.read_data || interrupt !== want.timer_interrupt) begin
            $display("%0t: read_data expected %02h actual %02h, interrupt expected %0b actual %0b",
                     $time, want.read_data, read_data, want.timer_interrupt, interrupt);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_operation = OP_TICK;
   logic [7:0] req_write_data = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic rsp_timer_interrupt;

   timer_scoreboard scoreboard;
   bit no_idle = 1'b0;
   bit long_hold_req = 1'b0;
   int unsigned cycle_count = 0;

   handheld_console_divider_timer_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_write_data(req_write_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_timer_interrupt(rsp_timer_interrupt)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("handheld_console_divider_timer_unit regression: fail");
         $finish;
      end
   end

   // Every accepted result goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         scoreboard.check_result(rsp_read_data, rsp_timer_interrupt);
   end

   // Result side: random stalls before each item, plus one long hold on request.
   initial begin
      int unsigned pause;
      forever begin
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
         end
         pause = no_idle ? 0 : $urandom_range(0, 6);
         if (pause != 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Offers one item after a random gap and waits until it is taken.
   task automatic issue_item(input logic [3:0] op, input logic [7:0] data);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_write_data <= data;
      do @(posedge clock); while (req_stall);
      scoreboard.note_item(op, data);
   endtask

   // Stops offering items until every predicted result has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (scoreboard.awaited_rsp.size() != 0);
   endtask

   // Random access, biased toward ticks and near-overflow counter values.
   task automatic issue_random_item();
      int unsigned pick;
      logic [7:0] data;
      pick = $urandom_range(0, 99);
      data = 8'($urandom_range(0, 255));
      if (pick < 50) begin
         issue_item(OP_TICK, data);
      end else if (pick < 58) begin
         if ($urandom_range(0, 1) == 0)
            data = 8'hfc | data[1:0];
         issue_item(OP_WRITE_TIMA, data);
      end else if (pick < 63) begin
         issue_item(OP_WRITE_TMA, data);
      end else if (pick < 68) begin
         if ($urandom_range(0, 2) != 0)
            data[TAC_ENABLE_BIT] = 1'b1;
         issue_item(OP_WRITE_TAC, data);
      end else if (pick < 72) begin
         issue_item(OP_WRITE_DIV, data);
      end else if (pick < 94) begin
         issue_item(4'($urandom_range(OP_READ_DIV, OP_READ_TAC)), data);
      end else begin
         issue_item(4'($urandom_range(9, 15)), data);
      end
   endtask

   // Stimulus and final verdict.
   initial begin
      int unsigned seg;
      logic [7:0] ctl;
      scoreboard = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Glitch on disable, reload cancel, glitch on a DIV write, then the reload window.
      issue_item(OP_WRITE_TMA, 8'hab);
      issue_item(OP_WRITE_TAC, 8'h05);
      issue_item(OP_WRITE_TIMA, 8'hff);
      repeat (8) issue_item(OP_TICK, 8'h00);
      issue_item(OP_WRITE_TAC, 8'h01);
      issue_item(OP_WRITE_TIMA, 8'hff);
      issue_item(OP_WRITE_TAC, 8'h05);
      issue_item(OP_WRITE_DIV, 8'hff);
      repeat (4) issue_item(OP_TICK, 8'hff);
      issue_item(OP_WRITE_TIMA, 8'h33);
      issue_item(OP_WRITE_TMA, 8'hcd);
      issue_item(OP_READ_TIMA, 8'h00);
      issue_item(OP_TICK, 8'h00);
      issue_item(OP_WRITE_TAC, 8'hff);
      issue_item(OP_READ_TAC, 8'h00);
      issue_item(OP_READ_TMA, 8'h00);
      issue_item(4'hf, 8'hff);
      issue_item(OP_READ_DIV, 8'hff);
      drain_results();

      // Random segments, each opened by a setup that brings the counter near overflow.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         no_idle = ($urandom_range(0, 3) == 0);
         if (seg == 3) begin
            no_idle = 1'b1;
            long_hold_req = 1'b1;
         end
         if (seg == 7)
            drain_results();
         ctl = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 9) < 7) begin
            ctl[TAC_ENABLE_BIT] = 1'b1;
            if ($urandom_range(0, 1) == 0)
               ctl[1:0] = 2'd1;
         end
         issue_item(OP_WRITE_TAC, ctl);
         issue_item(OP_WRITE_TMA, 8'($urandom_range(0, 255)));
         issue_item(OP_WRITE_TIMA, 8'hf0 | 8'($urandom_range(0, 15)));
         repeat (SEGMENT_ITEMS) issue_random_item();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.awaited_rsp.size() == 0)
         $display("handheld_console_divider_timer_unit regression: pass");
      else
         $display("handheld_console_divider_timer_unit regression: fail");
      $finish;
   end

endmodule
